// File: rtl/quantity_limited_split_fifo_defines.svh
// Assertion macros used by the port-level checker in rtl/qlsf_checker.sv.
`ifndef QUANTITY_LIMITED_SPLIT_FIFO_DEFINES_SVH
`define QUANTITY_LIMITED_SPLIT_FIFO_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define QLSF_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("qlsf check failed");

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define QLSF_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("qlsf check failed");

`endif

// File: rtl/qlsf_pkg.sv
// Package: widths, word types, codes and cell control for the split FIFO.
`timescale 1ns / 1ps
package qlsf_pkg;

  localparam int DEPTH = 16;
  localparam int TAG_W = 16;
  localparam int AMT_W = 32;
  localparam int TOT_W = 40;
  localparam int SLK_W = 32;
  localparam int TOL_W = 16;
  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  typedef enum logic [2:0] {
    OP_PUSH  = 3'd0,
    OP_FRONT = 3'd1,
    OP_BACK  = 3'd2,
    OP_COUNT = 3'd3,
    OP_QTY   = 3'd4,
    OP_QTOL  = 3'd5
  } opcode_t;

  typedef enum logic [2:0] {
    ST_OK    = 3'd0,
    ST_OVER  = 3'd1,
    ST_DUP   = 3'd2,
    ST_EMPTY = 3'd3,
    ST_CNT   = 3'd4,
    ST_QTY   = 3'd5,
    ST_FULL  = 3'd6
  } status_t;

  typedef enum logic [0:0] {
    CFG_CAPACITY  = 1'b0,
    CFG_TOLERANCE = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic [2:0]       opcode;
    logic [TAG_W-1:0] entry_tag;
    logic [AMT_W-1:0] amount;
    logic [CNT_W-1:0] pop_count;
    logic [SLK_W-1:0] slack;
  } in_word_t;

  typedef struct packed {
    logic             has_entry;
    logic [TAG_W-1:0] out_tag;
    logic [AMT_W-1:0] out_amount;
    logic             last;
    logic [2:0]       status;
    logic [TOT_W-1:0] total_quantity;
    logic [CNT_W-1:0] entry_total;
  } out_word_t;

  typedef struct packed {
    logic shift;
    logic load;
    logic sub;
  } cell_ctrl_t;

endpackage

// File: rtl/quantity_limited_split_fifo.sv
// Top level: quantity-limited split FIFO with a row of entry cells.
//
// Use: a command word enters on in_valid/in_stall; each command yields one
// or more result words on out_valid/out_stall, the final one flagged by
// last (opcodes six and seven give no word). Every word of a command shows
// the same status and the total and entry count after the command.
// Registers are written on cfg_valid/cfg_ready (always ready): index 0 the
// capacity, index 1 the push tolerance; write them only while idle.
// Entries sit packed in the cell row, front in cell 0; a front pop shifts
// every cell one place towards the front together.
// Flow: one command at a time. Push and single pops pass a check state and
// an emit state, which registers the result word; the next command is taken
// once that word is registered. Count and quantity pops first walk the
// affected entries, one cell a cycle, to learn the final totals, then hand
// out one word a cycle while the receiver does not stall; the next command
// is taken once the last word is registered.
// Reset clears the counters, the registers (capacity all ones, tolerance
// zero) and the output valid; cell contents stay undefined until pushed.
// A stalled receiver holds the output word; the block waits, nothing lost.
`timescale 1ns / 1ps
module quantity_limited_split_fifo (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  qlsf_pkg::in_word_t   in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output qlsf_pkg::out_word_t  out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic                 cfg_index,
  input  logic [31:0]          cfg_data
);

  localparam int DEPTH = qlsf_pkg::DEPTH;
  localparam int TAG_W = qlsf_pkg::TAG_W;
  localparam int AMT_W = qlsf_pkg::AMT_W;
  localparam int TOT_W = qlsf_pkg::TOT_W;
  localparam int IDX_W = qlsf_pkg::IDX_W;
  localparam int CNT_W = qlsf_pkg::CNT_W;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_CHECK = 4'b0010,
    S_SCAN  = 4'b0100,
    S_EMIT  = 4'b1000
  } state_t;

  typedef enum logic [2:0] {
    M_SINGLE = 3'd0,
    M_FRONT  = 3'd1,
    M_BACK   = 3'd2,
    M_COUNT  = 3'd3,
    M_QTY    = 3'd4
  } mode_t;

  // Control and command registers
  state_t                    state_r, state_nxt;
  mode_t                     mode_r, mode_nxt;
  qlsf_pkg::status_t         stat_r, stat_nxt;
  logic [2:0]                op_r;
  logic [TAG_W-1:0]          tag_r;
  logic [AMT_W-1:0]          amt_r;
  logic [qlsf_pkg::SLK_W-1:0] slack_r;
  logic [CNT_W-1:0]          pcnt_r;
  logic [CNT_W-1:0]          cnt_r, cnt_nxt;
  logic [AMT_W-1:0]          want_r, want_nxt;
  logic [AMT_W-1:0]          rem_r, rem_nxt;
  logic [TOT_W-1:0]          acc_r, acc_nxt;
  logic [CNT_W-1:0]          scan_r, scan_nxt;
  logic [TOT_W-1:0]          fin_total_r, fin_total_nxt;
  logic [CNT_W-1:0]          fin_cnt_r, fin_cnt_nxt;
  logic [TOT_W-1:0]          total_r, total_nxt;
  logic [CNT_W-1:0]          count_r, count_nxt;
  logic [AMT_W-1:0]          cap_r;
  logic [qlsf_pkg::TOL_W-1:0] tol_r;
  logic                      out_valid_r, out_valid_nxt;
  qlsf_pkg::out_word_t       out_data_r, out_data_nxt;

  // Cell row
  qlsf_pkg::cell_ctrl_t      ctrl_w [DEPTH];
  logic [TAG_W-1:0]          ctag_w [DEPTH];
  logic [AMT_W-1:0]          camt_w [DEPTH];
  logic                      match_w [DEPTH];

  logic                      load_en;
  logic                      shift_en;
  logic                      sub_en;
  logic                      dup;
  logic                      ov_free;
  logic [IDX_W-1:0]          push_idx;
  logic [IDX_W-1:0]          back_idx;
  logic [IDX_W-1:0]          scan_idx;
  logic [AMT_W-1:0]          scan_amt;
  logic [TOT_W:0]            push_sum;
  logic [TOT_W:0]            push_lim;
  logic [TOT_W:0]            tol_lim;

  genvar g;
  generate
    for (g = 0; g < DEPTH; g++) begin : g_cell
      logic [TAG_W-1:0] nb_tag;
      logic [AMT_W-1:0] nb_amt;
      if (g == DEPTH - 1) begin : g_end
        assign nb_tag = '0;
        assign nb_amt = '0;
      end else begin : g_mid
        assign nb_tag = ctag_w[g+1];
        assign nb_amt = camt_w[g+1];
      end

      assign ctrl_w[g].shift = shift_en;
      assign ctrl_w[g].load  = load_en && (push_idx == IDX_W'(g));
      assign ctrl_w[g].sub   = sub_en && (g == 0);

      qlsf_cell u_cell (
        .clk     (clk),
        .ctrl    (ctrl_w[g]),
        .nb_tag  (nb_tag),
        .nb_amt  (nb_amt),
        .ld_tag  (tag_r),
        .ld_amt  (amt_r),
        .sub_amt (want_r),
        .cmp_tag (tag_r),
        .tag     (ctag_w[g]),
        .amt     (camt_w[g]),
        .match   (match_w[g])
      );
    end
  endgenerate

  assign push_idx = count_r[IDX_W-1:0];
  assign back_idx = IDX_W'(count_r - CNT_W'(1));
  assign scan_idx = scan_r[IDX_W-1:0];
  assign scan_amt = camt_w[scan_idx];
  assign ov_free  = !out_valid_r || !out_stall;

  assign push_sum = (TOT_W+1)'(amt_r) + (TOT_W+1)'(total_r);
  assign push_lim = (TOT_W+1)'(cap_r) + (TOT_W+1)'(tol_r);
  assign tol_lim  = (TOT_W+1)'(total_r) + (TOT_W+1)'(slack_r);

  // Duplicate search: each live cell compares its tag in parallel
  always_comb begin
    dup = 1'b0;
    for (int i = 0; i < DEPTH; i++) begin
      if ((CNT_W'(i) < count_r) && match_w[i]) dup = 1'b1;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    mode_nxt      = mode_r;
    stat_nxt      = stat_r;
    cnt_nxt       = cnt_r;
    want_nxt      = want_r;
    rem_nxt       = rem_r;
    acc_nxt       = acc_r;
    scan_nxt      = scan_r;
    fin_total_nxt = fin_total_r;
    fin_cnt_nxt   = fin_cnt_r;
    total_nxt     = total_r;
    count_nxt     = count_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    load_en       = 1'b0;
    shift_en      = 1'b0;
    sub_en        = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) state_nxt = S_CHECK;
      end

      S_CHECK: begin
        // Decide the status; single-word commands settle their totals here
        stat_nxt      = qlsf_pkg::ST_OK;
        mode_nxt      = M_SINGLE;
        fin_total_nxt = total_r;
        fin_cnt_nxt   = count_r;
        scan_nxt      = '0;
        acc_nxt       = '0;
        state_nxt     = S_EMIT;
        unique case (op_r)
          qlsf_pkg::OP_PUSH: begin
            priority if (push_sum > push_lim) begin
              stat_nxt = qlsf_pkg::ST_OVER;
            end else if (dup) begin
              stat_nxt = qlsf_pkg::ST_DUP;
            end else if (count_r == CNT_W'(DEPTH)) begin
              stat_nxt = qlsf_pkg::ST_FULL;
            end else begin
              fin_total_nxt = total_r + TOT_W'(amt_r);
              fin_cnt_nxt   = count_r + CNT_W'(1);
            end
          end
          qlsf_pkg::OP_FRONT, qlsf_pkg::OP_BACK: begin
            if (count_r == '0) begin
              stat_nxt = qlsf_pkg::ST_EMPTY;
            end else begin
              mode_nxt    = (op_r == qlsf_pkg::OP_FRONT) ? M_FRONT : M_BACK;
              fin_cnt_nxt = count_r - CNT_W'(1);
              fin_total_nxt = total_r - TOT_W'((op_r == qlsf_pkg::OP_FRONT) ?
                                               camt_w[0] : camt_w[back_idx]);
            end
          end
          qlsf_pkg::OP_COUNT: begin
            if (pcnt_r > count_r) begin
              stat_nxt = qlsf_pkg::ST_CNT;
            end else begin
              mode_nxt  = M_COUNT;
              cnt_nxt   = pcnt_r;
              state_nxt = S_SCAN;
            end
          end
          qlsf_pkg::OP_QTY: begin
            if (TOT_W'(amt_r) > total_r) begin
              stat_nxt = qlsf_pkg::ST_QTY;
            end else begin
              mode_nxt  = M_QTY;
              want_nxt  = amt_r;
              rem_nxt   = amt_r;
              state_nxt = S_SCAN;
            end
          end
          qlsf_pkg::OP_QTOL: begin
            priority if ((TOT_W+1)'(amt_r) > tol_lim) begin
              stat_nxt = qlsf_pkg::ST_QTY;
            end else if (TOT_W'(amt_r) >= total_r) begin
              // Request covers everything: drain the whole store
              mode_nxt  = M_COUNT;
              cnt_nxt   = count_r;
              state_nxt = S_SCAN;
            end else begin
              mode_nxt  = M_QTY;
              want_nxt  = amt_r;
              rem_nxt   = amt_r;
              state_nxt = S_SCAN;
            end
          end
          default: begin
            state_nxt = S_IDLE;
          end
        endcase
      end

      S_SCAN: begin
        // Walk the front cells to learn the final total and count
        if (mode_r == M_COUNT) begin
          if (scan_r == cnt_r) begin
            fin_total_nxt = total_r - acc_r;
            fin_cnt_nxt   = count_r - cnt_r;
            state_nxt     = S_EMIT;
          end else begin
            acc_nxt  = acc_r + TOT_W'(scan_amt);
            scan_nxt = scan_r + CNT_W'(1);
          end
        end else begin
          if ((rem_r == '0) || (scan_r == count_r)) begin
            fin_total_nxt = total_r - TOT_W'(amt_r);
            fin_cnt_nxt   = count_r - scan_r;
            state_nxt     = S_EMIT;
          end else if (scan_amt > rem_r) begin
            rem_nxt = '0;
          end else begin
            rem_nxt  = rem_r - scan_amt;
            scan_nxt = scan_r + CNT_W'(1);
          end
        end
      end

      S_EMIT: begin
        if (ov_free) begin
          out_valid_nxt                 = 1'b1;
          out_data_nxt.has_entry        = 1'b0;
          out_data_nxt.out_tag          = '0;
          out_data_nxt.out_amount       = '0;
          out_data_nxt.last             = 1'b1;
          out_data_nxt.status           = stat_r;
          out_data_nxt.total_quantity   = fin_total_r;
          out_data_nxt.entry_total      = fin_cnt_r;
          unique case (mode_r)
            M_SINGLE: begin
              load_en = (op_r == qlsf_pkg::OP_PUSH) && (stat_r == qlsf_pkg::ST_OK);
            end
            M_FRONT: begin
              out_data_nxt.has_entry  = 1'b1;
              out_data_nxt.out_tag    = ctag_w[0];
              out_data_nxt.out_amount = camt_w[0];
              shift_en                = 1'b1;
            end
            M_BACK: begin
              out_data_nxt.has_entry  = 1'b1;
              out_data_nxt.out_tag    = ctag_w[back_idx];
              out_data_nxt.out_amount = camt_w[back_idx];
            end
            M_COUNT: begin
              if (cnt_r != '0) begin
                out_data_nxt.has_entry  = 1'b1;
                out_data_nxt.out_tag    = ctag_w[0];
                out_data_nxt.out_amount = camt_w[0];
                out_data_nxt.last       = (cnt_r == CNT_W'(1));
                shift_en                = 1'b1;
                cnt_nxt                 = cnt_r - CNT_W'(1);
              end
            end
            M_QTY: begin
              if (want_r != '0) begin
                out_data_nxt.has_entry = 1'b1;
                out_data_nxt.out_tag   = ctag_w[0];
                if (camt_w[0] > want_r) begin
                  // Split: hand out what is owed, keep the rest in front
                  out_data_nxt.out_amount = want_r;
                  sub_en                  = 1'b1;
                  want_nxt                = '0;
                end else begin
                  out_data_nxt.out_amount = camt_w[0];
                  out_data_nxt.last       = (want_r == camt_w[0]) ||
                                            (count_r == CNT_W'(1));
                  shift_en                = 1'b1;
                  want_nxt                = want_r - camt_w[0];
                end
              end
            end
            default: begin
            end
          endcase
          if (out_data_nxt.last) begin
            total_nxt = fin_total_r;
            count_nxt = fin_cnt_r;
            state_nxt = S_IDLE;
          end else begin
            count_nxt = count_r - CNT_W'(1);
          end
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      total_r     <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
      cap_r       <= '1;
      tol_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      total_r     <= total_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid) begin
        unique case (qlsf_pkg::cfg_reg_t'(cfg_index))
          qlsf_pkg::CFG_CAPACITY:  cap_r <= cfg_data;
          qlsf_pkg::CFG_TOLERANCE: tol_r <= cfg_data[qlsf_pkg::TOL_W-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  // Working registers: no reset, each loaded before it is read
  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && in_valid) begin
      op_r    <= in_data.opcode;
      tag_r   <= in_data.entry_tag;
      amt_r   <= in_data.amount;
      slack_r <= in_data.slack;
      pcnt_r  <= in_data.pop_count;
    end
    mode_r      <= mode_nxt;
    stat_r      <= stat_nxt;
    cnt_r       <= cnt_nxt;
    want_r      <= want_nxt;
    rem_r       <= rem_nxt;
    acc_r       <= acc_nxt;
    scan_r      <= scan_nxt;
    fin_total_r <= fin_total_nxt;
    fin_cnt_r   <= fin_cnt_nxt;
    out_data_r  <= out_data_nxt;
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign cfg_ready = 1'b1;

endmodule

// File: rtl/qlsf_cell.sv
// One storage cell of the entry row: tag, amount and a tag comparator.
`timescale 1ns / 1ps
module qlsf_cell (
  input  logic                           clk,
  input  qlsf_pkg::cell_ctrl_t           ctrl,
  input  logic [qlsf_pkg::TAG_W-1:0]     nb_tag,
  input  logic [qlsf_pkg::AMT_W-1:0]     nb_amt,
  input  logic [qlsf_pkg::TAG_W-1:0]     ld_tag,
  input  logic [qlsf_pkg::AMT_W-1:0]     ld_amt,
  input  logic [qlsf_pkg::AMT_W-1:0]     sub_amt,
  input  logic [qlsf_pkg::TAG_W-1:0]     cmp_tag,
  output logic [qlsf_pkg::TAG_W-1:0]     tag,
  output logic [qlsf_pkg::AMT_W-1:0]     amt,
  output logic                           match
);

  logic [qlsf_pkg::TAG_W-1:0] tag_r;
  logic [qlsf_pkg::AMT_W-1:0] amt_r;

  always_ff @(posedge clk) begin
    priority if (ctrl.shift) begin
      tag_r <= nb_tag;
      amt_r <= nb_amt;
    end else if (ctrl.load) begin
      tag_r <= ld_tag;
      amt_r <= ld_amt;
    end else if (ctrl.sub) begin
      amt_r <= amt_r - sub_amt;
    end
  end

  assign tag   = tag_r;
  assign amt   = amt_r;
  assign match = (tag_r == cmp_tag);

endmodule

// File: rtl/qlsf_checker.sv
// Port-level checker for the split FIFO, bound to the top level.
`timescale 1ns / 1ps
`include "quantity_limited_split_fifo_defines.svh"
module qlsf_props (
  input logic                clk,
  input logic                rst_n,
  input logic                out_valid,
  input logic                out_stall,
  input qlsf_pkg::out_word_t out_data
);

  logic blank_fields;

  assign blank_fields = (out_data.out_tag == '0) && (out_data.out_amount == '0);

  `QLSF_ASSERT_NXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data))
  `QLSF_ASSERT_IMP(a_mid_has_entry, out_valid && !out_data.last, out_data.has_entry)
  `QLSF_ASSERT_IMP(a_empty_zero, out_valid && !out_data.has_entry, blank_fields)
  `QLSF_ASSERT_IMP(a_count_range, out_valid, out_data.entry_total <= qlsf_pkg::DEPTH)

endmodule

bind quantity_limited_split_fifo qlsf_props u_qlsf_props (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

// File: dv/qlsf_checker.sv
// Checker: watches the command and result channels, predicts result words and compares them.
`timescale 1ns / 1ps
module qlsf_checker (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_stall,
  input  qlsf_pkg::in_word_t  in_data,
  input  logic                out_valid,
  input  logic                out_stall,
  input  qlsf_pkg::out_word_t out_data,
  input  logic                cfg_valid,
  input  logic                cfg_ready,
  input  logic                cfg_index,
  input  logic [31:0]         cfg_data,
  output int                  fail_count,
  output int                  pending_words
);

  logic [qlsf_pkg::TAG_W-1:0] tags [qlsf_pkg::DEPTH];
  logic [qlsf_pkg::AMT_W-1:0] amts [qlsf_pkg::DEPTH];
  logic [qlsf_pkg::IDX_W-1:0] head;
  int                         count;
  logic [qlsf_pkg::TOT_W-1:0] total;
  logic [31:0]                capacity;
  logic [qlsf_pkg::TOL_W-1:0] tolerance;

  qlsf_pkg::out_word_t expected_words[$];
  qlsf_pkg::out_word_t cmd_words[$];

  assign pending_words = expected_words.size();

  // Hand out the front entry whole.
  task automatic take_front();
    qlsf_pkg::out_word_t w;
    w = '0;
    w.has_entry = 1'b1;
    w.out_tag = tags[head];
    w.out_amount = amts[head];
    cmd_words.insert(cmd_words.size(), w);
    total = total - amts[head];
    head = head + 1'b1;
    count--;
  endtask

  // Walk the front, splitting the head entry when it exceeds what is owed.
  task automatic take_quantity(input logic [63:0] owed);
    qlsf_pkg::out_word_t w;
    while (owed > 0 && count > 0) begin
      if (amts[head] > owed) begin
        w = '0;
        w.has_entry = 1'b1;
        w.out_tag = tags[head];
        w.out_amount = owed[qlsf_pkg::AMT_W-1:0];
        cmd_words.insert(cmd_words.size(), w);
        amts[head] = amts[head] - owed[qlsf_pkg::AMT_W-1:0];
        total = total - owed[qlsf_pkg::TOT_W-1:0];
        owed = 0;
      end else begin
        owed = owed - amts[head];
        take_front();
      end
    end
  endtask

  // Close the command: stamp status, totals and last, queue the words.
  task automatic close_command(input qlsf_pkg::status_t st);
    qlsf_pkg::out_word_t w;
    if (cmd_words.size() == 0) cmd_words.insert(0, '0);
    foreach (cmd_words[k]) begin
      w = cmd_words[k];
      w.last = (k == cmd_words.size() - 1);
      w.status = st;
      w.total_quantity = total;
      w.entry_total = count[qlsf_pkg::CNT_W-1:0];
      expected_words.insert(expected_words.size(), w);
    end
    cmd_words.delete();
  endtask

  task automatic predict_command(input qlsf_pkg::in_word_t c);
    logic [63:0]                sum;
    logic                       dup;
    logic [qlsf_pkg::IDX_W-1:0] s;
    cmd_words.delete();
    case (c.opcode)
      qlsf_pkg::OP_PUSH: begin
        sum = 64'(c.amount) + 64'(total);
        dup = 1'b0;
        for (int i = 0; i < count; i++) begin
          if (tags[qlsf_pkg::IDX_W'(head + i)] == c.entry_tag) dup = 1'b1;
        end
        if (sum > 64'(capacity) + 64'(tolerance)) close_command(qlsf_pkg::ST_OVER);
        else if (dup) close_command(qlsf_pkg::ST_DUP);
        else if (count >= qlsf_pkg::DEPTH) close_command(qlsf_pkg::ST_FULL);
        else begin
          s = qlsf_pkg::IDX_W'(head + count);
          tags[s] = c.entry_tag;
          amts[s] = c.amount;
          count++;
          total = total + c.amount;
          close_command(qlsf_pkg::ST_OK);
        end
      end
      qlsf_pkg::OP_FRONT, qlsf_pkg::OP_BACK: begin
        if (count == 0) close_command(qlsf_pkg::ST_EMPTY);
        else if (c.opcode == qlsf_pkg::OP_FRONT) begin
          take_front();
          close_command(qlsf_pkg::ST_OK);
        end else begin
          qlsf_pkg::out_word_t w;
          s = qlsf_pkg::IDX_W'(head + count - 1);
          w = '0;
          w.has_entry = 1'b1;
          w.out_tag = tags[s];
          w.out_amount = amts[s];
          cmd_words.insert(cmd_words.size(), w);
          total = total - amts[s];
          count--;
          close_command(qlsf_pkg::ST_OK);
        end
      end
      qlsf_pkg::OP_COUNT: begin
        if (c.pop_count > count) close_command(qlsf_pkg::ST_CNT);
        else begin
          for (int i = 0; i < c.pop_count; i++) take_front();
          close_command(qlsf_pkg::ST_OK);
        end
      end
      qlsf_pkg::OP_QTY: begin
        if (40'(c.amount) > total) close_command(qlsf_pkg::ST_QTY);
        else begin
          take_quantity(64'(c.amount));
          close_command(qlsf_pkg::ST_OK);
        end
      end
      qlsf_pkg::OP_QTOL: begin
        if (64'(c.amount) > 64'(total) + 64'(c.slack)) close_command(qlsf_pkg::ST_QTY);
        else if (40'(c.amount) >= total) begin
          while (count > 0) take_front();
          close_command(qlsf_pkg::ST_OK);
        end else begin
          take_quantity(64'(c.amount));
          close_command(qlsf_pkg::ST_OK);
        end
      end
      default: ;
    endcase
  endtask

  always @(posedge clk) begin
    qlsf_pkg::out_word_t exp_w;
    if (!rst_n) begin
      head = '0;
      count = 0;
      total = '0;
      capacity = '1;
      tolerance = '0;
      fail_count = 0;
      expected_words.delete();
    end else begin
      // Compare the result word first: it belongs to an earlier command.
      if (out_valid && !out_stall) begin
        if (expected_words.size() == 0) begin
          $display("%0t: unexpected result word, expected none, actual %h", $time, out_data);
          fail_count++;
        end else begin
          exp_w = expected_words[0];
          expected_words.delete(0);
          if (out_data !== exp_w) begin
            $display("%0t: result mismatch, expected %h, actual %h", $time, exp_w, out_data);
            fail_count++;
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == qlsf_pkg::CFG_CAPACITY) capacity = cfg_data;
        else tolerance = cfg_data[qlsf_pkg::TOL_W-1:0];
      end
      if (in_valid && !in_stall) predict_command(in_data);
    end
  end

endmodule

// File: dv/testbench.sv
// Testbench top: clock, reset, command stimulus, register phases and the verdict.
`timescale 1ns / 1ps
module testbench;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  qlsf_pkg::in_word_t  in_data = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  qlsf_pkg::out_word_t out_data;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic                cfg_index = 1'b0;
  logic [31:0]         cfg_data = '0;
  int                  fail_count;
  int                  pending_words;

  // Small tag pool so that duplicates turn up often.
  logic [15:0] tag_pool [8] = '{16'h0000, 16'hFFFF, 16'h0001, 16'h8000,
                                16'h1234, 16'h7FFF, 16'hA5A5, 16'h5A5A};

  always #6 clk = ~clk;

  quantity_limited_split_fifo i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  qlsf_checker i_checker (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .fail_count(fail_count), .pending_words(pending_words)
  );

  // Receiver: hold stall for a random stretch before each word.
  initial begin
    int gap;
    forever begin
      @(negedge clk);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 13);
      out_stall <= (gap != 0);
      repeat (gap) @(negedge clk);
      out_stall <= 1'b0;
      // Release until a word has passed.
      @(posedge clk);
      while (!(out_valid && !out_stall)) @(posedge clk);
    end
  end

  // Offer one command word after an idle gap, if any, and hold it until it is taken.
  task automatic send_word(input qlsf_pkg::in_word_t w, input int gap);
    @(negedge clk);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_data  <= w;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic send_command(input qlsf_pkg::opcode_t op, input logic [15:0] tag,
                              input logic [31:0] amt, input logic [4:0] cnt,
                              input logic [31:0] slk);
    qlsf_pkg::in_word_t w;
    w.opcode = op;
    w.entry_tag = tag;
    w.amount = amt;
    w.pop_count = cnt;
    w.slack = slk;
    send_word(w, ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(0, 13));
  endtask

  // Drop valid, drain all expected words, then allow the longest walk to settle.
  task automatic wait_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_words != 0) @(negedge clk);
    repeat (50) @(negedge clk);
  endtask

  task automatic write_reg(input qlsf_pkg::cfg_reg_t idx, input logic [31:0] value);
    @(negedge clk);
    cfg_index <= idx;
    cfg_data  <= value;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Random command: mostly pushes and pops with sensible sizes, some raw noise.
  task automatic random_command(input logic [31:0] amt_max);
    qlsf_pkg::in_word_t w;
    logic [95:0]        raw;
    int                 sel;
    raw = {$urandom, $urandom, $urandom};
    w = raw[$bits(qlsf_pkg::in_word_t)-1:0];
    sel = $urandom_range(0, 19);
    w.entry_tag = ($urandom_range(0, 1)) ? tag_pool[$urandom_range(0, 7)] : 16'($urandom);
    if (sel < 8) begin
      w.opcode = qlsf_pkg::OP_PUSH;
      w.amount = ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, amt_max);
    end else if (sel < 10) w.opcode = qlsf_pkg::OP_FRONT;
    else if (sel < 12) w.opcode = qlsf_pkg::OP_BACK;
    else if (sel < 14) begin
      w.opcode = qlsf_pkg::OP_COUNT;
      w.pop_count = 5'($urandom_range(0, 5));
    end else if (sel < 16) begin
      w.opcode = qlsf_pkg::OP_QTY;
      w.amount = $urandom_range(0, 2 * amt_max);
    end else if (sel < 18) begin
      w.opcode = qlsf_pkg::OP_QTOL;
      w.amount = $urandom_range(0, 3 * amt_max);
      w.slack = ($urandom_range(0, 1)) ? $urandom_range(0, amt_max) : $urandom;
    end else if (sel == 18) begin
      w.opcode = qlsf_pkg::OP_COUNT;
      w.pop_count = 5'($urandom_range(0, 31));
    end
    send_word(w, ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(0, 13));
  endtask

  initial begin
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: reset register values first.
    send_command(qlsf_pkg::OP_FRONT, '0, '0, '0, '0);
    send_command(qlsf_pkg::OP_BACK, '0, '0, '0, '0);
    send_command(qlsf_pkg::OP_QTOL, '0, '0, '0, '0);
    send_command(qlsf_pkg::OP_COUNT, '0, '0, '0, '0);
    send_command(qlsf_pkg::OP_QTY, '0, 32'd1, '0, '0);
    send_command(qlsf_pkg::OP_PUSH, 16'hFFFF, 32'hFFFF_FFFF, '0, '0);
    send_command(qlsf_pkg::OP_PUSH, 16'h0000, 32'h0000_0001, '0, '0);
    send_command(qlsf_pkg::OP_PUSH, 16'h0000, '0, '0, '0);
    send_command(qlsf_pkg::OP_PUSH, 16'h0001, '0, '0, '0);
    send_command(qlsf_pkg::OP_QTY, '0, 32'h8000_0000, '0, '0);
    send_command(qlsf_pkg::OP_QTY, '0, 32'h8000_0000, '0, '0);
    send_command(qlsf_pkg::OP_COUNT, '0, '0, 5'd2, '0);
    send_command(qlsf_pkg::OP_COUNT, '0, '0, 5'd31, '0);
    send_command(qlsf_pkg::OP_QTOL, '0, 32'hFFFF_FFFF, '0, 32'hFFFF_FFFF);
    wait_idle();
    // Extremes of the registers: no capacity, then full tolerance.
    write_reg(qlsf_pkg::CFG_CAPACITY, 32'd0);
    write_reg(qlsf_pkg::CFG_TOLERANCE, 32'h0000_FFFF);
    send_command(qlsf_pkg::OP_PUSH, 16'h0002, 32'h0000_FFFF, '0, '0);
    send_command(qlsf_pkg::OP_PUSH, 16'h0003, 32'h0000_0001, '0, '0);
    for (int i = 0; i < 17; i++) send_command(qlsf_pkg::OP_PUSH, 16'(i + 16), '0, '0, '0);
    send_command(qlsf_pkg::OP_QTOL, '0, 32'h0001_0000, '0, 32'd1);
    send_command(qlsf_pkg::OP_COUNT, '0, '0, 5'd16, '0);
    send_command(qlsf_pkg::OP_COUNT, '0, '0, 5'd0, '0);
    wait_idle();

    // Random phases over several register settings.
    for (int phase = 0; phase < 5; phase++) begin
      case (phase)
        0: begin
          write_reg(qlsf_pkg::CFG_CAPACITY, 32'hFFFF_FFFF);
          write_reg(qlsf_pkg::CFG_TOLERANCE, 32'd0);
        end
        1: begin
          write_reg(qlsf_pkg::CFG_CAPACITY, 32'd5000);
          write_reg(qlsf_pkg::CFG_TOLERANCE, 32'd300);
        end
        2: begin
          write_reg(qlsf_pkg::CFG_CAPACITY, 32'd20);
          write_reg(qlsf_pkg::CFG_TOLERANCE, 32'hFFFF);
        end
        3: begin
          write_reg(qlsf_pkg::CFG_CAPACITY, $urandom);
          write_reg(qlsf_pkg::CFG_TOLERANCE, $urandom);
        end
        default: begin
          write_reg(qlsf_pkg::CFG_CAPACITY, 32'd0);
          write_reg(qlsf_pkg::CFG_TOLERANCE, 32'd0);
        end
      endcase
      for (int n = 0; n < 73; n++) random_command((phase == 0) ? 32'hFFFF_FFFF : 32'd1000);
      wait_idle();
    end

    if (fail_count == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end

  initial begin
    #20ms;
    $display("Verification failed");
    $finish;
  end

endmodule
